// ===== sv/rfm_pkg.sv =====
// Shared types, key codes and colour tables for the RGB fade mode controller.
package rfm_pkg;

  localparam logic [31:0] KEY_CYCLE  = 32'd2907897600;
  localparam logic [31:0] KEY_RED    = 32'd4077715200;
  localparam logic [31:0] KEY_CYAN   = 32'd3877175040;
  localparam logic [31:0] KEY_WHITE  = 32'd2707357440;
  localparam logic [31:0] KEY_YELLOW = 32'd4144561920;
  localparam logic [31:0] KEY_BLUE   = 32'd3810328320;
  localparam logic [31:0] KEY_PINK   = 32'd2774204160;
  localparam logic [31:0] KEY_GREEN  = 32'd3175284480;

  localparam logic [7:0] RAMP_TOP = 8'd255;

  localparam logic [2:0] COLOUR_OFF    = 3'd0;
  localparam logic [2:0] COLOUR_RED    = 3'd1;
  localparam logic [2:0] COLOUR_CYAN   = 3'd2;
  localparam logic [2:0] COLOUR_WHITE  = 3'd3;
  localparam logic [2:0] COLOUR_YELLOW = 3'd4;
  localparam logic [2:0] COLOUR_BLUE   = 3'd5;
  localparam logic [2:0] COLOUR_PINK   = 3'd6;
  localparam logic [2:0] COLOUR_GREEN  = 3'd7;

  localparam logic [3:0] MODE_CYCLE = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_CYCLE,
    CMD_COLOUR,
    CMD_IGNORE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] colour;
  } cmd_t;

  // Channel mask of a colour: bit 2 red, bit 1 green, bit 0 blue.
  function automatic logic [2:0] colour_mask(input logic [2:0] colour);
    logic [2:0] m;
    unique case (colour)
      COLOUR_OFF:    m = 3'b000;
      COLOUR_RED:    m = 3'b100;
      COLOUR_CYAN:   m = 3'b011;
      COLOUR_WHITE:  m = 3'b111;
      COLOUR_YELLOW: m = 3'b110;
      COLOUR_BLUE:   m = 3'b001;
      COLOUR_PINK:   m = 3'b101;
      COLOUR_GREEN:  m = 3'b010;
      default:       m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/rgb_fade_mode_controller.sv =====
// Top level of the RGB fade mode controller: front end, queue and fade engine.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    action, key_code
//   out      out_valid/out_ready  red_level, green_level, blue_level, active_mode
//
// Each input beat yields one output beat; one beat per cycle is sustained
// while out_ready stays high. A beat passes the decoder and a two-entry
// queue, then the fade engine registers the result. The output register
// is updated only when the engine takes a command, so a stalled output
// holds its beat while the queue accepts input until both entries are full.
// Reset clears the queue, the output valid and all mode and ramp state.
module rgb_fade_mode_controller import rfm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_level,
  output logic [7:0]  green_level,
  output logic [7:0]  blue_level,
  output logic [3:0]  active_mode
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  rfm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .key_code  (key_code),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  rfm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  rfm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (back_valid),
    .cmd_ready   (back_ready),
    .cmd         (back_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .active_mode (active_mode)
  );

endmodule

// ===== sv/rfm_front.sv =====
// Front end: accepts input beats and classifies them into commands.
module rfm_front import rfm_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] key_code,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  always_comb begin
    cmd.colour = COLOUR_OFF;
    if (!action) begin
      cmd.kind = CMD_TICK;
    end else begin
      priority if (key_code == KEY_CYCLE) begin
        cmd.kind = CMD_CYCLE;
      end else if (key_code == KEY_RED) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_RED;
      end else if (key_code == KEY_CYAN) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_CYAN;
      end else if (key_code == KEY_WHITE) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_WHITE;
      end else if (key_code == KEY_YELLOW) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_YELLOW;
      end else if (key_code == KEY_BLUE) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_BLUE;
      end else if (key_code == KEY_PINK) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_PINK;
      end else if (key_code == KEY_GREEN) begin
        cmd.kind   = CMD_COLOUR;
        cmd.colour = COLOUR_GREEN;
      end else begin
        cmd.kind = CMD_IGNORE;
      end
    end
  end

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

endmodule

// ===== sv/rfm_queue.sv =====
// Short command queue between the front end and the fade engine.
module rfm_queue import rfm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pop;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rfm_back.sv =====
// Fade engine: mode state, ramp and the registered result beat.
module rfm_back import rfm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red_level,
  output logic [7:0] green_level,
  output logic [7:0] blue_level,
  output logic [3:0] active_mode
);

  logic       cycle_on, cycle_on_next;
  logic [2:0] single_colour, single_colour_next;
  logic [2:0] cycle_idx, cycle_idx_next;
  logic       ramp_falling, ramp_falling_next;
  logic [7:0] ramp_level, ramp_level_next;
  logic [7:0] red, red_next;
  logic [7:0] green, green_next;
  logic [7:0] blue, blue_next;
  logic       take;
  logic [2:0] colour;
  logic [2:0] mask;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign colour    = cycle_on ? cycle_idx : single_colour;
  assign mask      = colour_mask(colour);

  always_comb begin
    cycle_on_next      = cycle_on;
    single_colour_next = single_colour;
    cycle_idx_next     = cycle_idx;
    ramp_falling_next  = ramp_falling;
    ramp_level_next    = ramp_level;
    red_next           = red;
    green_next         = green;
    blue_next          = blue;
    unique case (cmd.kind)
      CMD_TICK: begin
        if (colour != COLOUR_OFF) begin
          red_next   = mask[2] ? ramp_level : '0;
          green_next = mask[1] ? ramp_level : '0;
          blue_next  = mask[0] ? ramp_level : '0;
          if (!ramp_falling) begin
            ramp_level_next = ramp_level + 1'b1;
            if (ramp_level_next == RAMP_TOP) begin
              ramp_falling_next = 1'b1;
            end
          end else begin
            ramp_level_next = ramp_level - 1'b1;
            if (ramp_level_next == '0) begin
              ramp_falling_next = 1'b0;
              if (cycle_on) begin
                cycle_idx_next = (cycle_idx == COLOUR_GREEN) ? COLOUR_RED : cycle_idx + 1'b1;
              end
            end
          end
        end
      end
      CMD_CYCLE: begin
        if (!cycle_on) begin
          single_colour_next = COLOUR_OFF;
          cycle_on_next      = 1'b1;
          cycle_idx_next     = COLOUR_RED;
          ramp_level_next    = '0;
          ramp_falling_next  = 1'b0;
        end else begin
          cycle_on_next = 1'b0;
          red_next      = '0;
          green_next    = '0;
          blue_next     = '0;
        end
      end
      CMD_COLOUR: begin
        if (single_colour != cmd.colour) begin
          cycle_on_next      = 1'b0;
          single_colour_next = cmd.colour;
          ramp_level_next    = '0;
          ramp_falling_next  = 1'b0;
        end else begin
          single_colour_next = COLOUR_OFF;
          red_next           = '0;
          green_next         = '0;
          blue_next          = '0;
        end
      end
      CMD_IGNORE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      cycle_on      <= 1'b0;
      single_colour <= COLOUR_OFF;
      cycle_idx     <= COLOUR_RED;
      ramp_falling  <= 1'b0;
      ramp_level    <= '0;
      red           <= '0;
      green         <= '0;
      blue          <= '0;
    end else begin
      if (take) begin
        out_valid     <= 1'b1;
        cycle_on      <= cycle_on_next;
        single_colour <= single_colour_next;
        cycle_idx     <= cycle_idx_next;
        ramp_falling  <= ramp_falling_next;
        ramp_level    <= ramp_level_next;
        red           <= red_next;
        green         <= green_next;
        blue          <= blue_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign red_level   = red;
  assign green_level = green;
  assign blue_level  = blue;
  assign active_mode = cycle_on ? MODE_CYCLE : {1'b0, single_colour};

endmodule

// ===== sim/tb_rgb_fade_mode_controller.sv =====
// Self-checking testbench for the RGB fade mode controller with a queue-fed driver and monitor.
module tb_rgb_fade_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import rfm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 80;
  localparam int FLOOD_BEATS = 40;
  localparam int SWEEP_TICKS = 600;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    logic        act;
    logic [31:0] code;
    int unsigned gap;
    bit          flood;
    bit          drain;
  } remote_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] mode;
  } fade_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [31:0] key_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;
  logic [3:0]  active_mode;

  remote_item_t remote_items[$];
  fade_beat_t   expected_levels[$];
  remote_item_t cur_item;
  bit           item_held = 1'b0;
  int unsigned  gap_left = 0;
  bit           live_flood = 1'b0;
  bit           tx_calm = 1'b0;

  bit           in_beat_done = 1'b0;
  bit           out_beat_done = 1'b0;
  bit           flood_seen = 1'b0;
  bit           hold_done = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  rx_beats = 0;
  bit           rx_calm = 1'b0;
  int unsigned  cycles = 0;
  int unsigned  errors = 0;

  bit          run_cycle = 1'b0;
  logic [2:0]  solo_colour = COLOUR_OFF;
  logic [2:0]  cycle_colour = COLOUR_RED;
  bit          ramp_down = 1'b0;
  logic [7:0]  ramp = 8'd0;
  logic [7:0]  lvl_r = 8'd0;
  logic [7:0]  lvl_g = 8'd0;
  logic [7:0]  lvl_b = 8'd0;

  logic [31:0] mode_keys[8] = '{KEY_CYCLE, KEY_RED, KEY_CYAN, KEY_WHITE,
                                KEY_YELLOW, KEY_BLUE, KEY_PINK, KEY_GREEN};

  rgb_fade_mode_controller u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .key_code(key_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level),
    .active_mode(active_mode)
  );

  function automatic fade_beat_t advance_fade(input logic act, input logic [31:0] code);
    logic [2:0] pressed;
    logic [2:0] colour;
    logic [2:0] mask;
    fade_beat_t r;
    pressed = COLOUR_OFF;
    if (act) begin
      case (code)
        KEY_CYCLE: begin
          if (!run_cycle) begin
            solo_colour = COLOUR_OFF;
            run_cycle = 1'b1;
            cycle_colour = COLOUR_RED;
            ramp = 8'd0;
            ramp_down = 1'b0;
          end else begin
            lvl_r = 8'd0;
            lvl_g = 8'd0;
            lvl_b = 8'd0;
            run_cycle = 1'b0;
          end
        end
        KEY_RED:    pressed = COLOUR_RED;
        KEY_CYAN:   pressed = COLOUR_CYAN;
        KEY_WHITE:  pressed = COLOUR_WHITE;
        KEY_YELLOW: pressed = COLOUR_YELLOW;
        KEY_BLUE:   pressed = COLOUR_BLUE;
        KEY_PINK:   pressed = COLOUR_PINK;
        KEY_GREEN:  pressed = COLOUR_GREEN;
        default:    pressed = COLOUR_OFF;
      endcase
      if (pressed != COLOUR_OFF) begin
        if (solo_colour != pressed) begin
          run_cycle = 1'b0;
          solo_colour = pressed;
          ramp = 8'd0;
          ramp_down = 1'b0;
        end else begin
          lvl_r = 8'd0;
          lvl_g = 8'd0;
          lvl_b = 8'd0;
          solo_colour = COLOUR_OFF;
        end
      end
    end else begin
      colour = run_cycle ? cycle_colour : solo_colour;
      if (colour != COLOUR_OFF) begin
        case (colour)
          COLOUR_RED:    mask = 3'b100;
          COLOUR_CYAN:   mask = 3'b011;
          COLOUR_WHITE:  mask = 3'b111;
          COLOUR_YELLOW: mask = 3'b110;
          COLOUR_BLUE:   mask = 3'b001;
          COLOUR_PINK:   mask = 3'b101;
          COLOUR_GREEN:  mask = 3'b010;
          default:       mask = 3'b000;
        endcase
        lvl_r = mask[2] ? ramp : 8'd0;
        lvl_g = mask[1] ? ramp : 8'd0;
        lvl_b = mask[0] ? ramp : 8'd0;
        if (!ramp_down) begin
          ramp = ramp + 8'd1;
          if (ramp == RAMP_TOP) ramp_down = 1'b1;
        end else begin
          ramp = ramp - 8'd1;
          if (ramp == 8'd0) begin
            ramp_down = 1'b0;
            if (run_cycle) begin
              cycle_colour = (cycle_colour == COLOUR_GREEN) ? COLOUR_RED :
                             3'(cycle_colour + 3'd1);
            end
          end
        end
      end
    end
    r.red = lvl_r;
    r.green = lvl_g;
    r.blue = lvl_b;
    r.mode = run_cycle ? MODE_CYCLE : {1'b0, solo_colour};
    return r;
  endfunction

  task automatic add_item(input logic act, input logic [31:0] code,
                          input bit flood = 1'b0, input bit drain = 1'b0);
    remote_item_t it;
    it.act = act;
    it.code = code;
    it.gap = tx_calm ? 0 : $urandom_range(0, 19);
    it.flood = flood;
    it.drain = drain;
    remote_items.push_back(it);
  endtask

  task automatic add_ticks(input int count);
    repeat (count) add_item(1'b0, $urandom);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    int kind;
    int n;
    int target;
    bit drain;
    logic [31:0] key;
    logic [31:0] key2;

    add_item(1'b0, '0);
    add_item(1'b1, 32'h0000_0000);
    add_item(1'b1, 32'hFFFF_FFFF);
    add_item(1'b0, KEY_RED);
    add_item(1'b1, KEY_RED);
    add_ticks(2);
    add_item(1'b1, KEY_RED);
    add_ticks(1);
    add_item(1'b1, KEY_CYAN);
    add_ticks(2);
    add_item(1'b1, KEY_WHITE);
    add_ticks(1);
    add_item(1'b1, KEY_YELLOW);
    add_ticks(1);
    add_item(1'b1, KEY_BLUE);
    add_ticks(1);
    add_item(1'b1, KEY_PINK);
    add_ticks(1);
    add_item(1'b1, KEY_GREEN);
    add_ticks(1);
    add_item(1'b1, KEY_CYCLE);
    add_ticks(2);
    add_item(1'b1, KEY_CYCLE);
    add_ticks(1);

    // Cycle-mode sweep over a whole red ramp and on into cyan, opened by a
    // back-to-back burst while the receiver holds off.
    tx_calm = 1'b1;
    add_item(1'b1, KEY_CYCLE, 1'b1, 1'b1);
    add_ticks(FLOOD_BEATS);
    for (int i = FLOOD_BEATS; i < SWEEP_TICKS; i += 100) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      add_ticks(100);
    end
    tx_calm = 1'b0;
    add_item(1'b1, KEY_CYCLE, 1'b0, 1'b1);

    target = remote_items.size() + RANDOM_ITEMS;
    while (remote_items.size() < target) begin
      kind = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 4) == 0);
      drain = ($urandom_range(0, 11) == 0);
      key = mode_keys[3'($urandom_range(0, 7))];
      key2 = mode_keys[3'($urandom_range(0, 7))];
      if (kind <= 6) begin
        add_item(1'b1, key, 1'b0, drain);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 30);
        repeat (n) begin
          if ($urandom_range(0, 15) == 0) add_item(1'b1, $urandom);
          else add_item(1'b0, $urandom);
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 5)) add_item(1'($urandom_range(0, 1)), $urandom);
      end else if (kind == 8) begin
        add_item(1'b1, key, 1'b0, drain);
        add_ticks($urandom_range(0, 3));
        add_item(1'b1, key);
        add_ticks($urandom_range(1, 4));
      end else begin
        add_item(1'b1, key, 1'b0, drain);
        add_ticks($urandom_range(0, 6));
        add_item(1'b1, key2);
        add_ticks($urandom_range(1, 10));
      end
    end
    tx_calm = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (remote_items.size() != 0 || item_held || in_valid || expected_levels.size() != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(posedge clk) begin
    fade_beat_t want;
    cycles++;
    in_beat_done = !rst && in_valid && in_ready;
    out_beat_done = !rst && out_valid && out_ready;
    if (out_beat_done) begin
      if (expected_levels.size() == 0) begin
        $error("output beat with no expected result: red %0d green %0d blue %0d mode %0d",
               red_level, green_level, blue_level, active_mode);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        check_field("red_level", int'(want.red), int'(red_level));
        check_field("green_level", int'(want.green), int'(green_level));
        check_field("blue_level", int'(want.blue), int'(blue_level));
        check_field("active_mode", int'(want.mode), int'(active_mode));
      end
    end
    if (in_beat_done) begin
      expected_levels.push_back(advance_fade(action, key_code));
      if (live_flood) flood_seen = 1'b1;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid && !in_beat_done;
      if (!nv) begin
        if (!item_held && remote_items.size() != 0) begin
          cur_item = remote_items.pop_front();
          item_held = 1'b1;
          gap_left = cur_item.gap;
        end
        if (item_held && !(cur_item.drain && expected_levels.size() != 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            nv = 1'b1;
            action <= cur_item.act;
            key_code <= cur_item.code;
            live_flood = cur_item.flood;
            item_held = 1'b0;
          end
        end
      end
      in_valid <= nv;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (flood_seen && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (out_beat_done) begin
        rx_beats++;
        if (rx_beats % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, 19);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/rfm_pkg.sv
sv/rfm_front.sv
sv/rfm_queue.sv
sv/rfm_back.sv
sv/rgb_fade_mode_controller.sv
sim/tb_rgb_fade_mode_controller.sv
